@@ hdl/kmd_pkg.sv @@
`default_nettype none

package kmd_pkg;

    // Default matrix size.
    localparam int DEF_ROWS = 8;
    localparam int DEF_COLS = 8;

    // Register reset values, in milliseconds.
    localparam logic [15:0] DEBOUNCE_RESET = 16'd5;
    localparam logic [15:0] HOLD_RESET     = 16'd500;

    // Configuration register indexes.
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  REG_DEBOUNCE = 2'd0;
    localparam logic [1:0]  REG_HOLD     = 2'd1;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_HOLD    = 2'd2
    } t_kind;

    // Per-key state as it is stored in the key memory.
    typedef struct packed {
        logic        hold_reported;
        logic        stable_level;
        logic        last_raw_level;
        logic [31:0] change_time;
    } t_key_state;

    localparam int STATE_W = $bits(t_key_state);

    // Outcome of one key update.
    typedef struct packed {
        logic  has_event;
        t_kind kind;
    } t_upd;

endpackage

`default_nettype wire

@@ hdl/key_matrix_debounce_events.sv @@
`default_nettype none

// Per-key debounce and event generator for a keyboard matrix. Each input
// transaction carries one raw sample of one key (row, column, level) and a
// free-running millisecond timestamp; the block keeps, for every key, its last
// raw level, the time of its last raw edge, the debounced level and a
// hold-reported flag in a single key memory. When the raw level has been
// stable for debounce_time ms the debounced level follows and a press or
// release event is sent; a key held for hold_time ms since its last raw edge
// sends one hold event. Samples outside the matrix are dropped. Rate: one
// sample per clock, limited by the one read and one write port of the key
// memory; outside the clearing pass the input stalls only while an event
// waits on a stalled output. Each event passes the stage-two register
// into the output register. After reset the block clears the key memory
// before the first sample; configuration writes are taken at any time.
module key_matrix_debounce_events #(
    parameter int ROWS = kmd_pkg::DEF_ROWS,
    parameter int COLS = kmd_pkg::DEF_COLS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Sample stream.
    input  wire logic                         s_axis_tvalid,
    output      logic                         s_axis_tready,
    // [2:0] sample_row, [5:3] sample_col, [6] raw_pressed, [38:7] time_ms
    input  wire logic [39:0]                  s_axis_tdata,
    // Event stream.
    output      logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [2:0] event_row, [5:3] event_col
    output      logic [7:0]                   m_axis_tdata,
    // [1:0] event_kind
    output      logic [1:0]                   m_axis_tuser,
    // Configuration writes.
    input  wire logic                         i_cfg_valid,
    output      logic                         o_cfg_ready,
    input  wire logic [kmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                  i_cfg_data
);

    localparam int DEPTH = ROWS * COLS;
    localparam int KEY_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STATE_W_L = kmd_pkg::STATE_W;

    // Configuration registers. The port never back-pressures.
    logic [15:0] r_debounce;
    logic [15:0] r_hold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= kmd_pkg::DEBOUNCE_RESET;
            r_hold     <= kmd_pkg::HOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kmd_pkg::REG_DEBOUNCE: r_debounce <= i_cfg_data;
                kmd_pkg::REG_HOLD:     r_hold     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input field unpacking and key index.
    logic [2:0]  in_row;
    logic [2:0]  in_col;
    logic        in_raw;
    logic [31:0] in_now;
    logic        in_range;
    logic [10:0] key_full;
    logic [KEY_W-1:0] in_key;

    assign in_row   = s_axis_tdata[2:0];
    assign in_col   = s_axis_tdata[5:3];
    assign in_raw   = s_axis_tdata[6];
    assign in_now   = s_axis_tdata[38:7];
    assign in_range = ({3'd0, in_row} < 6'(ROWS)) && ({3'd0, in_col} < 6'(COLS));
    assign key_full = 11'(in_row) * 11'(COLS) + 11'(in_col);
    assign in_key   = key_full[KEY_W-1:0];

    // Clearing pass after reset: one entry per cycle, written to zero.
    logic             r_clearing;
    logic [KEY_W-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == KEY_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Second stage: the memory read issued at acceptance returns here.
    logic             r_s1_v;
    logic             r_s1_inr;
    logic [KEY_W-1:0] r_s1_key;
    logic [2:0]       r_s1_row;
    logic [2:0]       r_s1_col;
    logic             r_s1_raw;
    logic [31:0]      r_s1_now;

    // Forwarding of the write that lands on the same edge as the read.
    logic                r_fwd_v;
    logic [KEY_W-1:0]    r_fwd_key;
    kmd_pkg::t_key_state r_fwd_data;

    // Output register.
    logic          r_o_valid;
    kmd_pkg::t_kind r_o_kind;
    logic [2:0]    r_o_row;
    logic [2:0]    r_o_col;

    logic                 s_accept;
    logic                 s1_done;
    logic                 out_free;
    logic                 wr_en;
    logic                 ev_load;
    logic [STATE_W_L-1:0] ram_rdata;
    kmd_pkg::t_key_state  cur_state;
    kmd_pkg::t_key_state  new_state;
    kmd_pkg::t_upd        upd;
    logic                 ram_we;
    logic [KEY_W-1:0]     ram_waddr;
    logic [STATE_W_L-1:0] ram_wdata;

    kmd_ram #(
        .WIDTH (STATE_W_L),
        .DEPTH (DEPTH)
    ) u_key_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (s_accept),
        .i_raddr (in_key),
        .o_rdata (ram_rdata)
    );

    assign cur_state = (r_fwd_v && (r_fwd_key == r_s1_key)) ? r_fwd_data
                                                            : kmd_pkg::t_key_state'(ram_rdata);

    kmd_keyupd u_keyupd (
        .i_state    (cur_state),
        .i_raw      (r_s1_raw),
        .i_now      (r_s1_now),
        .i_debounce (r_debounce),
        .i_hold     (r_hold),
        .o_state    (new_state),
        .o_upd      (upd)
    );

    // An event may leave stage two only into a free or draining output register.
    assign out_free      = !r_o_valid || m_axis_tready;
    assign s1_done       = r_s1_v && (!(r_s1_inr && upd.has_event) || out_free);
    assign wr_en         = s1_done && r_s1_inr;
    assign ev_load       = wr_en && upd.has_event;
    assign s_axis_tready = !r_clearing && (!r_s1_v || s1_done);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign ram_we    = r_clearing || wr_en;
    assign ram_waddr = r_clearing ? r_clr_cnt : r_s1_key;
    assign ram_wdata = r_clearing ? '0 : new_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            if (s_accept) begin
                r_s1_v  <= 1'b1;
                r_fwd_v <= wr_en;
            end else if (s1_done) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_inr   <= in_range;
            r_s1_key   <= in_key;
            r_s1_row   <= in_row;
            r_s1_col   <= in_col;
            r_s1_raw   <= in_raw;
            r_s1_now   <= in_now;
            r_fwd_key  <= r_s1_key;
            r_fwd_data <= new_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ev_load) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_load) begin
            r_o_kind <= upd.kind;
            r_o_row  <= r_s1_row;
            r_o_col  <= r_s1_col;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {2'b00, r_o_col, r_o_row};
    assign m_axis_tuser  = r_o_kind;

endmodule

`default_nettype wire

@@ hdl/kmd_ram.sv @@
`default_nettype none

module kmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/kmd_keyupd.sv @@
`default_nettype none

module kmd_keyupd (
    input  wire kmd_pkg::t_key_state i_state,
    input  wire logic                i_raw,
    input  wire logic [31:0]         i_now,
    input  wire logic [15:0]         i_debounce,
    input  wire logic [15:0]         i_hold,
    output      kmd_pkg::t_key_state o_state,
    output      kmd_pkg::t_upd       o_upd
);

    logic [31:0] elapsed;
    logic        settled;
    logic        held;

    assign elapsed = i_now - i_state.change_time;
    assign settled = (elapsed >= {16'd0, i_debounce});
    assign held    = (elapsed >= {16'd0, i_hold});

    always_comb begin
        o_state         = i_state;
        o_upd.has_event = 1'b0;
        o_upd.kind      = kmd_pkg::KIND_PRESS;
        if (i_raw != i_state.last_raw_level) begin
            // A raw edge only restarts the timer and records the new raw level.
            o_state.change_time    = i_now;
            o_state.last_raw_level = i_raw;
        end else if (settled) begin
            o_state.stable_level = i_raw;
            if (i_raw && !i_state.stable_level) begin
                o_upd.has_event       = 1'b1;
                o_upd.kind            = kmd_pkg::KIND_PRESS;
                o_state.hold_reported = 1'b0;
            end else if (!i_raw && i_state.stable_level) begin
                o_upd.has_event       = 1'b1;
                o_upd.kind            = kmd_pkg::KIND_RELEASE;
                o_state.hold_reported = 1'b0;
            end else if (i_raw && !i_state.hold_reported && held) begin
                o_upd.has_event       = 1'b1;
                o_upd.kind            = kmd_pkg::KIND_HOLD;
                o_state.hold_reported = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
